@@ rtl/bsat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsat_pkg;

	localparam int COORD_BITS     = 24;
	localparam int TRIG_FRAC_BITS = 14;

	localparam int TW = TRIG_FRAC_BITS + 2;   // trig word
	localparam int HB = COORD_BITS - 1;       // half size
	localparam int DW = COORD_BITS + 1;       // centre difference
	localparam int TP = 2 * TW;               // trig product
	localparam int NB = TP + 1;               // sum of two trig products
	localparam int NM = TP;                   // magnitude of that sum
	localparam int DP = TW + DW;              // trig times difference
	localparam int DS = DP + 1;               // sum of two of those
	localparam int DM = DP;                   // magnitude of that sum
	localparam int EP = NM + HB;              // extent product
	localparam int SW = (EP + 2 > DM + TRIG_FRAC_BITS) ? EP + 2 : DM + TRIG_FRAC_BITS;

	typedef struct packed {
		logic en_first;
		logic en_second;
	} stage_pair_t;

	typedef struct packed {
		logic [NM-1:0]        na;
		logic [NM-1:0]        nb;
		logic [NM-1:0]        p;
		logic [NM-1:0]        q;
		logic signed [DP-1:0] acdx;
		logic signed [DP-1:0] asdy;
		logic signed [DP-1:0] asdx;
		logic signed [DP-1:0] acdy;
		logic signed [DP-1:0] bcdx;
		logic signed [DP-1:0] bsdy;
		logic signed [DP-1:0] bsdx;
		logic signed [DP-1:0] bcdy;
		logic [HB-1:0]        a_hw;
		logic [HB-1:0]        a_hh;
		logic [HB-1:0]        b_hw;
		logic [HB-1:0]        b_hh;
	} front_t;

	typedef struct packed {
		logic [SW-1:0] dist_ra;
		logic [SW-1:0] dist_ua;
		logic [SW-1:0] dist_rb;
		logic [SW-1:0] dist_ub;
		logic [SW-1:0] ext_ra;
		logic [SW-1:0] ext_ua;
		logic [SW-1:0] ext_rb;
		logic [SW-1:0] ext_ub;
	} proj_t;

endpackage

`default_nettype wire

@@ rtl/bsat_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsat_front import bsat_pkg::*; (
	input  logic                         clk,
	input  stage_pair_t                  ctl,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic        [HB-1:0]         a_half_w,
	input  logic        [HB-1:0]         a_half_h,
	input  logic signed [TW-1:0]         a_cos,
	input  logic signed [TW-1:0]         a_sin,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic        [HB-1:0]         b_half_w,
	input  logic        [HB-1:0]         b_half_h,
	input  logic signed [TW-1:0]         b_cos,
	input  logic signed [TW-1:0]         b_sin,
	output front_t                       front
);

	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [TP-1:0] caa_s1, saa_s1, cbb_s1, sbb_s1;
	logic signed [TP-1:0] cab_s1, sab_s1, sacb_s1, casb_s1;
	logic signed [TW-1:0] a_c_s1, a_s_s1, b_c_s1, b_s_s1;
	logic [HB-1:0]        a_hw_s1, a_hh_s1, b_hw_s1, b_hh_s1;

	always_ff @(posedge clk) begin
		if (ctl.en_first) begin
			dx_s1   <= DW'(a_center_x) - DW'(b_center_x);
			dy_s1   <= DW'(a_center_y) - DW'(b_center_y);
			caa_s1  <= a_cos * a_cos;
			saa_s1  <= a_sin * a_sin;
			cbb_s1  <= b_cos * b_cos;
			sbb_s1  <= b_sin * b_sin;
			cab_s1  <= a_cos * b_cos;
			sab_s1  <= a_sin * b_sin;
			sacb_s1 <= a_sin * b_cos;
			casb_s1 <= a_cos * b_sin;
			a_c_s1  <= a_cos;
			a_s_s1  <= a_sin;
			b_c_s1  <= b_cos;
			b_s_s1  <= b_sin;
			a_hw_s1 <= a_half_w;
			a_hh_s1 <= a_half_h;
			b_hw_s1 <= b_half_w;
			b_hh_s1 <= b_half_h;
		end
	end

	// cross-box dots: |rA.rB| = |uA.uB| = p, |rA.uB| = |uA.rB| = q; rA.uA = 0
	logic signed [NB-1:0] na_sum, nb_sum, p_sum, q_sum;
	logic [NM-1:0]        p_mag, q_mag;

	always_comb begin
		na_sum = NB'(caa_s1) + NB'(saa_s1);
		nb_sum = NB'(cbb_s1) + NB'(sbb_s1);
		p_sum  = NB'(cab_s1) + NB'(sab_s1);
		q_sum  = NB'(sacb_s1) - NB'(casb_s1);
		p_mag  = p_sum[NB-1] ? NM'(-p_sum) : NM'(p_sum);
		q_mag  = q_sum[NB-1] ? NM'(-q_sum) : NM'(q_sum);
	end

	logic [NM-1:0]        na_s2, nb_s2, p_s2, q_s2;
	logic signed [DP-1:0] acdx_s2, asdy_s2, asdx_s2, acdy_s2;
	logic signed [DP-1:0] bcdx_s2, bsdy_s2, bsdx_s2, bcdy_s2;
	logic [HB-1:0]        a_hw_s2, a_hh_s2, b_hw_s2, b_hh_s2;

	always_ff @(posedge clk) begin
		if (ctl.en_second) begin
			na_s2   <= NM'(na_sum);
			nb_s2   <= NM'(nb_sum);
			p_s2    <= p_mag;
			q_s2    <= q_mag;
			acdx_s2 <= a_c_s1 * dx_s1;
			asdy_s2 <= a_s_s1 * dy_s1;
			asdx_s2 <= a_s_s1 * dx_s1;
			acdy_s2 <= a_c_s1 * dy_s1;
			bcdx_s2 <= b_c_s1 * dx_s1;
			bsdy_s2 <= b_s_s1 * dy_s1;
			bsdx_s2 <= b_s_s1 * dx_s1;
			bcdy_s2 <= b_c_s1 * dy_s1;
			a_hw_s2 <= a_hw_s1;
			a_hh_s2 <= a_hh_s1;
			b_hw_s2 <= b_hw_s1;
			b_hh_s2 <= b_hh_s1;
		end
	end

	always_comb begin
		front.na   = na_s2;
		front.nb   = nb_s2;
		front.p    = p_s2;
		front.q    = q_s2;
		front.acdx = acdx_s2;
		front.asdy = asdy_s2;
		front.asdx = asdx_s2;
		front.acdy = acdy_s2;
		front.bcdx = bcdx_s2;
		front.bsdy = bsdy_s2;
		front.bsdx = bsdx_s2;
		front.bcdy = bcdy_s2;
		front.a_hw = a_hw_s2;
		front.a_hh = a_hh_s2;
		front.b_hw = b_hw_s2;
		front.b_hh = b_hh_s2;
	end

endmodule

`default_nettype wire

@@ rtl/bsat_project.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsat_project import bsat_pkg::*; (
	input  logic        clk,
	input  stage_pair_t ctl,
	input  front_t      front,
	output proj_t       proj
);

	logic signed [DS-1:0] d_ra, d_ua, d_rb, d_ub;
	logic [DM-1:0]        m_ra, m_ua, m_rb, m_ub;

	always_comb begin
		d_ra = DS'(front.acdx) + DS'(front.asdy);
		d_ua = DS'(front.acdy) - DS'(front.asdx);
		d_rb = DS'(front.bcdx) + DS'(front.bsdy);
		d_ub = DS'(front.bcdy) - DS'(front.bsdx);
		m_ra = d_ra[DS-1] ? DM'(-d_ra) : DM'(d_ra);
		m_ua = d_ua[DS-1] ? DM'(-d_ua) : DM'(d_ua);
		m_rb = d_rb[DS-1] ? DM'(-d_rb) : DM'(d_rb);
		m_ub = d_ub[DS-1] ? DM'(-d_ub) : DM'(d_ub);
	end

	logic [DM-1:0] m_ra_s3, m_ua_s3, m_rb_s3, m_ub_s3;
	logic [EP-1:0] na_ahw_s3, na_ahh_s3, nb_bhw_s3, nb_bhh_s3;
	logic [EP-1:0] p_bhw_s3, q_bhh_s3, q_bhw_s3, p_bhh_s3;
	logic [EP-1:0] p_ahw_s3, q_ahh_s3, q_ahw_s3, p_ahh_s3;

	always_ff @(posedge clk) begin
		if (ctl.en_first) begin
			m_ra_s3   <= m_ra;
			m_ua_s3   <= m_ua;
			m_rb_s3   <= m_rb;
			m_ub_s3   <= m_ub;
			na_ahw_s3 <= front.na * front.a_hw;
			na_ahh_s3 <= front.na * front.a_hh;
			nb_bhw_s3 <= front.nb * front.b_hw;
			nb_bhh_s3 <= front.nb * front.b_hh;
			p_bhw_s3  <= front.p * front.b_hw;
			q_bhh_s3  <= front.q * front.b_hh;
			q_bhw_s3  <= front.q * front.b_hw;
			p_bhh_s3  <= front.p * front.b_hh;
			p_ahw_s3  <= front.p * front.a_hw;
			q_ahh_s3  <= front.q * front.a_hh;
			q_ahw_s3  <= front.q * front.a_hw;
			p_ahh_s3  <= front.p * front.a_hh;
		end
	end

	logic [SW-1:0] dist_ra_s4, dist_ua_s4, dist_rb_s4, dist_ub_s4;
	logic [SW-1:0] ext_ra_s4, ext_ua_s4, ext_rb_s4, ext_ub_s4;

	always_ff @(posedge clk) begin
		if (ctl.en_second) begin
			dist_ra_s4 <= SW'(m_ra_s3) << TRIG_FRAC_BITS;
			dist_ua_s4 <= SW'(m_ua_s3) << TRIG_FRAC_BITS;
			dist_rb_s4 <= SW'(m_rb_s3) << TRIG_FRAC_BITS;
			dist_ub_s4 <= SW'(m_ub_s3) << TRIG_FRAC_BITS;
			ext_ra_s4  <= SW'(na_ahw_s3) + SW'(p_bhw_s3) + SW'(q_bhh_s3);
			ext_ua_s4  <= SW'(na_ahh_s3) + SW'(q_bhw_s3) + SW'(p_bhh_s3);
			ext_rb_s4  <= SW'(p_ahw_s3) + SW'(q_ahh_s3) + SW'(nb_bhw_s3);
			ext_ub_s4  <= SW'(q_ahw_s3) + SW'(p_ahh_s3) + SW'(nb_bhh_s3);
		end
	end

	always_comb begin
		proj.dist_ra = dist_ra_s4;
		proj.dist_ua = dist_ua_s4;
		proj.dist_rb = dist_rb_s4;
		proj.dist_ub = dist_ub_s4;
		proj.ext_ra  = ext_ra_s4;
		proj.ext_ua  = ext_ua_s4;
		proj.ext_rb  = ext_rb_s4;
		proj.ext_ub  = ext_ub_s4;
	end

endmodule

`default_nettype wire

@@ rtl/bsat_compare.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsat_compare import bsat_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  proj_t proj,
	output logic  overlap
);

	logic sep;
	logic overlap_s5;

	// touching is overlap: only a strict excess separates
	always_comb begin
		sep = (proj.dist_ra > proj.ext_ra) || (proj.dist_ua > proj.ext_ua) ||
		      (proj.dist_rb > proj.ext_rb) || (proj.dist_ub > proj.ext_ub);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			overlap_s5 <= !sep;
		end
	end

	assign overlap = overlap_s5;

endmodule

`default_nettype wire

@@ rtl/box_separating_axis_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             payload
// in       in   in_valid / in_stall   a_* and b_* box fields
// out      out  out_valid / out_stall overlap
//
// Five register stages; one item per cycle while the output is not stalled.
// Stage 1 centre differences and trig products, stage 2 axis dots and
// centre projections, stage 3 extent products, stage 4 sums, stage 5 compare.
// Reset clears only the stage valid bits.
// A stalled output holds its stage; bubbles ahead of it still close up.

module box_separating_axis_test import bsat_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic        [HB-1:0]         a_half_w,
	input  logic        [HB-1:0]         a_half_h,
	input  logic signed [TW-1:0]         a_cos,
	input  logic signed [TW-1:0]         a_sin,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic        [HB-1:0]         b_half_w,
	input  logic        [HB-1:0]         b_half_h,
	input  logic signed [TW-1:0]         b_cos,
	input  logic signed [TW-1:0]         b_sin,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         overlap
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	stage_pair_t front_ctl, proj_ctl;
	front_t      front;
	proj_t       proj;

	always_comb begin
		en_s5 = !v_s5 || !out_stall;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
		front_ctl.en_first  = en_s1;
		front_ctl.en_second = en_s2;
		proj_ctl.en_first   = en_s3;
		proj_ctl.en_second  = en_s4;
	end

	assign in_stall  = !en_s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	bsat_front u_front (
		.clk        (clk),
		.ctl        (front_ctl),
		.a_center_x (a_center_x),
		.a_center_y (a_center_y),
		.a_half_w   (a_half_w),
		.a_half_h   (a_half_h),
		.a_cos      (a_cos),
		.a_sin      (a_sin),
		.b_center_x (b_center_x),
		.b_center_y (b_center_y),
		.b_half_w   (b_half_w),
		.b_half_h   (b_half_h),
		.b_cos      (b_cos),
		.b_sin      (b_sin),
		.front      (front)
	);

	bsat_project u_project (
		.clk   (clk),
		.ctl   (proj_ctl),
		.front (front),
		.proj  (proj)
	);

	bsat_compare u_compare (
		.clk     (clk),
		.en      (en_s5),
		.proj    (proj),
		.overlap (overlap)
	);

	// input is held off only when every stage is full and the output waits
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall))
		else $error("input stalled with a free stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item lost at stage 1");

	a_s4_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5) |=> v_s5)
		else $error("item lost between stage 4 and output");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && out_stall) |=> (v_s5 && $stable(overlap)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

@@ tb/sv/box_separating_axis_test_tb.sv @@
`timescale 1ns / 1ps

module box_separating_axis_test_tb import bsat_pkg::*; ();

	typedef struct {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic        [HB-1:0]         hw;
		logic        [HB-1:0]         hh;
		logic signed [TW-1:0]         c;
		logic signed [TW-1:0]         s;
	} box_t;

	localparam int Q_ONE = 1 << TRIG_FRAC_BITS;
	localparam int Q_DIAG = 11585;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_BITS-1:0] a_center_x = '0;
	logic signed [COORD_BITS-1:0] a_center_y = '0;
	logic        [HB-1:0]         a_half_w = '0;
	logic        [HB-1:0]         a_half_h = '0;
	logic signed [TW-1:0]         a_cos = '0;
	logic signed [TW-1:0]         a_sin = '0;
	logic signed [COORD_BITS-1:0] b_center_x = '0;
	logic signed [COORD_BITS-1:0] b_center_y = '0;
	logic        [HB-1:0]         b_half_w = '0;
	logic        [HB-1:0]         b_half_h = '0;
	logic signed [TW-1:0]         b_cos = '0;
	logic signed [TW-1:0]         b_sin = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlap;

	bit expected_overlap[$];
	bit want_overlap;
	int errors = 0;
	int pairs_checked = 0;
	int overlapping_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	box_separating_axis_test dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_center_x (a_center_x),
		.a_center_y (a_center_y),
		.a_half_w   (a_half_w),
		.a_half_h   (a_half_h),
		.a_cos      (a_cos),
		.a_sin      (a_sin),
		.b_center_x (b_center_x),
		.b_center_y (b_center_y),
		.b_half_w   (b_half_w),
		.b_half_h   (b_half_h),
		.b_cos      (b_cos),
		.b_sin      (b_sin),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.overlap    (overlap)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// exact arithmetic: dots fit in 64 bits, extents and scaled gaps in 128
	function automatic logic [127:0] umag(longint v);
		if (v < 0)
			v = -v;
		return 128'(v);
	endfunction

	function automatic logic [127:0] reach(longint ax, longint ay, box_t bx);
		logic [127:0] hw, hh;
		longint c, s;
		c = bx.c;
		s = bx.s;
		hw = bx.hw;
		hh = bx.hh;
		return umag(ax * c + ay * s) * hw + umag(ay * c - ax * s) * hh;
	endfunction

	function automatic bit splits_on(longint ax, longint ay, longint dx, longint dy,
			box_t a, box_t b);
		logic [127:0] gap;
		gap = umag(ax * dx + ay * dy) << TRIG_FRAC_BITS;
		return gap > reach(ax, ay, a) + reach(ax, ay, b);
	endfunction

	function automatic bit boxes_overlap(box_t a, box_t b);
		longint dx, dy, ac, as_, bc, bs;
		dx = longint'(a.cx) - longint'(b.cx);
		dy = longint'(a.cy) - longint'(b.cy);
		ac = a.c;
		as_ = a.s;
		bc = b.c;
		bs = b.s;
		return !(splits_on(ac, as_, dx, dy, a, b) || splits_on(-as_, ac, dx, dy, a, b)
			|| splits_on(bc, bs, dx, dy, a, b) || splits_on(-bs, bc, dx, dy, a, b));
	endfunction

	function automatic box_t mk_box(longint cx, longint cy, longint hw, longint hh,
			longint c, longint s);
		box_t r;
		r.cx = COORD_BITS'(cx);
		r.cy = COORD_BITS'(cy);
		r.hw = HB'(hw);
		r.hh = HB'(hh);
		r.c = TW'(c);
		r.s = TW'(s);
		return r;
	endfunction

	function automatic logic signed [TW-1:0] q_trig(real v);
		integer k;
		k = $rtoi(v * real'(Q_ONE));
		return TW'(k);
	endfunction

	function automatic box_t near_box(longint bx, longint by);
		box_t r;
		real ang;
		ang = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
		r = mk_box(bx + longint'($urandom_range(0, 8000)) - 4000,
			by + longint'($urandom_range(0, 8000)) - 4000,
			$urandom_range(0, 3000), $urandom_range(0, 3000), 0, 0);
		if ($urandom_range(0, 7) == 0) begin
			r.c = TW'($urandom);
			r.s = TW'($urandom);
		end else begin
			r.c = q_trig($cos(ang));
			r.s = q_trig($sin(ang));
		end
		return r;
	endfunction

	function automatic box_t wild_box();
		return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic send_pair(box_t a, box_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		a_center_x <= a.cx;
		a_center_y <= a.cy;
		a_half_w <= a.hw;
		a_half_h <= a.hh;
		a_cos <= a.c;
		a_sin <= a.s;
		b_center_x <= b.cx;
		b_center_y <= b.cy;
		b_half_w <= b.hw;
		b_half_h <= b.hh;
		b_cos <= b.c;
		b_sin <= b.s;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_overlap = {expected_overlap, boxes_overlap(a, b)};
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_overlap.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_cases();
		box_t unit_a;
		unit_a = mk_box(0, 0, 256, 256, Q_ONE, 0);
		send_pair(mk_box(0, 0, 0, 0, Q_ONE, 0), mk_box(0, 0, 0, 0, Q_ONE, 0));
		// touching edges overlap, one step further separates
		send_pair(unit_a, mk_box(512, 0, 256, 256, Q_ONE, 0));
		send_pair(unit_a, mk_box(513, 0, 256, 256, Q_ONE, 0));
		send_pair(unit_a, mk_box(0, -512, 256, 256, Q_ONE, 0));
		send_pair(unit_a, mk_box(0, -513, 256, 256, Q_ONE, 0));
		send_pair(mk_box(0, 0, 256, 128, Q_DIAG, Q_DIAG),
			mk_box(600, 600, 256, 128, Q_DIAG, Q_DIAG));
		send_pair(unit_a, mk_box(700, 0, 256, 256, Q_DIAG, Q_DIAG));
		send_pair(unit_a, mk_box(600, 0, 256, 256, Q_DIAG, Q_DIAG));
		send_pair(unit_a, mk_box(560, 560, 256, 256, Q_DIAG, -Q_DIAG));
		// zero rotation vector on one box, then on both
		send_pair(mk_box(0, 0, 256, 256, 0, 0), mk_box(4000, 0, 256, 256, Q_ONE, 0));
		send_pair(mk_box(0, 0, 256, 256, 0, 0), mk_box(4000, 0, 256, 256, 0, 0));
		// out-of-range and non-unit trig words
		send_pair(mk_box(0, 0, 300, 100, -32768, 32767), mk_box(900, 200, 50, 400, 3, 0));
		send_pair(mk_box(0, 0, 300, 100, 32767, -32768), mk_box(-900, 50, 50, 400, 0, -1));
		send_pair(mk_box(0, 0, 256, 256, Q_ONE, Q_ONE), mk_box(520, 0, 256, 256, -Q_ONE, 0));
		send_pair(mk_box(0, 0, 256, 64, 0, Q_ONE), mk_box(300, 0, 256, 64, 0, -Q_ONE));
		// coordinate and size extremes
		send_pair(mk_box(8388607, 8388607, 0, 0, Q_ONE, 0),
			mk_box(-8388608, -8388608, 0, 0, Q_ONE, 0));
		send_pair(mk_box(8388607, 8388607, 8388607, 8388607, Q_ONE, 0),
			mk_box(-8388608, -8388608, 8388607, 8388607, Q_ONE, 0));
		send_pair(mk_box(-8388608, 8388607, 8388607, 0, -32768, -32768),
			mk_box(8388607, -8388608, 0, 8388607, 32767, 32767));
		send_pair(mk_box(-1, -1, 8388607, 8388607, -1, -1),
			mk_box(-1, -1, 8388607, 8388607, -1, -1));
		send_pair(mk_box(-8388608, -8388608, 8388607, 8388607, -Q_ONE, -Q_ONE),
			mk_box(-8388608, -8388608, 0, 0, Q_ONE, -Q_ONE));
	endtask

	task automatic test_near_pairs(int n);
		longint bx, by;
		for (int i = 0; i < n; i++) begin
			bx = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
			by = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
			send_pair(near_box(bx, by), near_box(bx, by));
		end
	endtask

	task automatic test_wide_random(int n);
		box_t a, b;
		for (int i = 0; i < n; i++) begin
			a = wild_box();
			b = wild_box();
			if ($urandom_range(0, 1) == 0) begin
				b.cx = a.cx + COORD_BITS'($urandom_range(0, 1 << 16));
				b.cy = a.cy - COORD_BITS'($urandom_range(0, 1 << 16));
			end
			send_pair(a, b);
		end
	endtask

	task automatic test_drain_pause();
		test_near_pairs(10);
		wait_drained();
		test_near_pairs(10);
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_overlap.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: overlap=%0b", $time, overlap);
			end else begin
				want_overlap = expected_overlap.pop_front();
				pairs_checked++;
				if (overlap === 1'b1)
					overlapping_seen++;
				if (overlap !== want_overlap) begin
					errors++;
					$display("%0t: overlap mismatch: expected %0b actual %0b",
						$time, want_overlap, overlap);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 72;
		test_corner_cases();
		test_near_pairs(150);
		test_wide_random(80);

		send_idle_pct = 72;
		recv_idle_pct = 24;
		test_near_pairs(140);
		test_drain_pause();
		test_wide_random(80);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_near_pairs(150);
		test_wide_random(80);

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_overlap.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_overlap.size());
		end
		$display("%0d box pairs checked, %0d overlapping and %0d separate,",
			pairs_checked, overlapping_seen, pairs_checked - overlapping_seen);
		$display("over corner cases, near and wide random pairs, three idle mixes, one drain");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ box_separating_axis_test.f @@
rtl/bsat_pkg.sv
rtl/bsat_front.sv
rtl/bsat_project.sv
rtl/bsat_compare.sv
rtl/box_separating_axis_test.sv
tb/sv/box_separating_axis_test_tb.sv
